FILE: rtl/core/frame_deframer_dd_77_top_macros.svh
// ----------------------------------------------------------------------------
// Frame deframer assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_DD_77_TOP_MACROS_SVH
`define FRAME_DEFRAMER_DD_77_TOP_MACROS_SVH

// Checked only while out of reset.
`define FDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fdd77_pkg.sv
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, codes and reset values shared by the frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdd77_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COMMAND_LOW  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COMMAND_HIGH = 2'd3;

  // Register reset values
  localparam logic [ByteW-1:0] END_BYTE_RST     = 8'h77;
  localparam logic [ByteW-1:0] MAX_PAYLOAD_RST  = 8'd52;
  localparam logic [ByteW-1:0] COMMAND_LOW_RST  = 8'h03;
  localparam logic [ByteW-1:0] COMMAND_HIGH_RST = 8'h05;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CMD  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_END  = 3'd3,
    ST_BAD_SUM  = 3'd4,
    ST_ABORTED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEAD    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] echo_byte;
    logic [IdxW-1:0]  byte_index;
    logic             last;
    status_t          status;
  } result_t;

endpackage

FILE: rtl/core/frame_deframer_dd_77_top.sv
// ----------------------------------------------------------------------------
// Frame deframer top
// Checks a 0xDD-style serial reply frame byte by byte: command range,
// length limit, 16-bit negated-sum checksum and end byte. Echoes each
// frame byte with its index; the last beat of a frame carries a status.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | in_valid/in_stall, rx_byte,        | in
//          | frame_start, abort                 |
//  result  | out_valid/out_stall, echo_byte,    | out
//          | byte_index, last, status           |
//  config  | cfg_we, cfg_index, cfg_wdata       | in
//
// One byte per cycle while in_stall is low. Results enter the output
// register, or the skid if held. A two-entry output buffer (output register
// plus skid) lets input flow under out_stall until the skid fills; in_stall
// rises once both entries are full. Synchronous active-low reset clears
// frame state and loads register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frame_deframer_dd_77_top_macros.svh"

module frame_deframer_dd_77_top
  import fdd77_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteW-1:0]     in_rx_byte,
  input  logic                 in_frame_start,
  input  logic                 in_abort,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ByteW-1:0]     out_echo_byte,
  output logic [IdxW-1:0]      out_byte_index,
  output logic                 out_last,
  output logic [2:0]           out_status,
  // configuration
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [ByteW-1:0]     cfg_wdata
);

  // configuration registers
  logic [ByteW-1:0] end_byte_r, max_payload_r, command_low_r, command_high_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [IdxW-1:0]  byte_count_r, byte_count_nxt;
  logic [ByteW-1:0] payload_length_r, payload_length_nxt;
  logic             length_high_nonzero_r, length_high_nonzero_nxt;
  logic             command_valid_r, command_valid_nxt;
  logic [SumW-1:0]  running_sum_r, running_sum_nxt;
  logic [ByteW-1:0] checksum_high_r, checksum_high_nxt;

  // output buffer
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic    in_accept, out_fire, has_res;
  result_t res;
  logic [SumW-1:0]  expect_sum;
  logic [ByteW-1:0] plen_dec;
  logic             sum_bad;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  assign expect_sum = ~running_sum_r + 16'd1;
  assign plen_dec   = payload_length_r - 8'd1;
  assign sum_bad    = (checksum_high_r != expect_sum[15:8]) ||
                      (in_rx_byte != expect_sum[7:0]);

  always_comb begin
    phase_nxt               = phase_r;
    byte_count_nxt          = byte_count_r;
    payload_length_nxt      = payload_length_r;
    length_high_nonzero_nxt = length_high_nonzero_r;
    command_valid_nxt       = command_valid_r;
    running_sum_nxt         = running_sum_r;
    checksum_high_nxt       = checksum_high_r;
    has_res                 = 1'b0;
    res                     = '{echo_byte: '0, byte_index: '0, last: 1'b0, status: ST_OK};

    if (in_abort) begin
      if (phase_r != PH_IDLE || in_frame_start) begin
        has_res        = 1'b1;
        res.byte_index = (phase_r != PH_IDLE) ? byte_count_r : '0;
        res.last       = 1'b1;
        res.status     = ST_ABORTED;
        phase_nxt      = PH_IDLE;
      end
    end else if (in_frame_start) begin
      command_valid_nxt       = (in_rx_byte >= command_low_r) &&
                                (in_rx_byte <= command_high_r);
      running_sum_nxt         = '0;
      length_high_nonzero_nxt = 1'b0;
      payload_length_nxt      = '0;
      phase_nxt               = PH_HEAD;
      byte_count_nxt          = IdxW'(1);
      has_res                 = 1'b1;
      res.echo_byte           = in_rx_byte;
    end else if (phase_r != PH_IDLE) begin
      has_res        = 1'b1;
      res.echo_byte  = in_rx_byte;
      res.byte_index = byte_count_r;
      byte_count_nxt = byte_count_r + IdxW'(1);
      unique case (phase_r)
        PH_HEAD: begin
          running_sum_nxt = running_sum_r + {8'd0, in_rx_byte};
          if (byte_count_r == IdxW'(1)) begin
            length_high_nonzero_nxt = (in_rx_byte != 8'd0);
          end else if (!command_valid_r) begin
            phase_nxt  = PH_IDLE;
            res.last   = 1'b1;
            res.status = ST_BAD_CMD;
          end else if (length_high_nonzero_r || in_rx_byte > max_payload_r) begin
            phase_nxt  = PH_IDLE;
            res.last   = 1'b1;
            res.status = ST_TOO_LONG;
          end else begin
            payload_length_nxt = in_rx_byte;
            phase_nxt          = (in_rx_byte != 8'd0) ? PH_PAYLOAD : PH_TRAILER;
          end
        end
        PH_PAYLOAD: begin
          running_sum_nxt    = running_sum_r + {8'd0, in_rx_byte};
          payload_length_nxt = plen_dec;
          if (plen_dec == 8'd0) begin
            phase_nxt = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          // payload_length now counts trailer bytes seen
          if (payload_length_r == 8'd0) begin
            checksum_high_nxt  = in_rx_byte;
            payload_length_nxt = 8'd1;
          end else if (payload_length_r == 8'd1) begin
            running_sum_nxt    = {15'd0, sum_bad};
            payload_length_nxt = 8'd2;
          end else begin
            phase_nxt = PH_IDLE;
            res.last  = 1'b1;
            if (in_rx_byte != end_byte_r) begin
              res.status = ST_BAD_END;
            end else if (running_sum_r != '0) begin
              res.status = ST_BAD_SUM;
            end else begin
              res.status = ST_OK;
            end
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_byte_r     <= END_BYTE_RST;
      max_payload_r  <= MAX_PAYLOAD_RST;
      command_low_r  <= COMMAND_LOW_RST;
      command_high_r <= COMMAND_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_END_BYTE:     end_byte_r     <= cfg_wdata;
        CFG_MAX_PAYLOAD:  max_payload_r  <= cfg_wdata;
        CFG_COMMAND_LOW:  command_low_r  <= cfg_wdata;
        CFG_COMMAND_HIGH: command_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r               <= PH_IDLE;
      byte_count_r          <= '0;
      payload_length_r      <= '0;
      length_high_nonzero_r <= 1'b0;
      command_valid_r       <= 1'b0;
      running_sum_r         <= '0;
      checksum_high_r       <= '0;
    end else if (in_accept) begin
      phase_r               <= phase_nxt;
      byte_count_r          <= byte_count_nxt;
      payload_length_r      <= payload_length_nxt;
      length_high_nonzero_r <= length_high_nonzero_nxt;
      command_valid_r       <= command_valid_nxt;
      running_sum_r         <= running_sum_nxt;
      checksum_high_r       <= checksum_high_nxt;
    end
  end

  // output register + skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept && has_res;
      end
    end else if (in_accept && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_accept && has_res) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_echo_byte  = out_r.echo_byte;
  assign out_byte_index = out_r.byte_index;
  assign out_last       = out_r.last;
  assign out_status     = out_r.status;

  // ---------------------------------------------------------------------------
  // assertions
  `FDD_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid beat without output beat")
  `FDD_ASSERT(a_status_on_last, (out_valid_r && out_r.status != ST_OK) |-> out_r.last, "error status on non-last beat")
  `FDD_ASSERT(a_abort_to_idle, (in_accept && in_abort) |=> (phase_r == PH_IDLE), "abort left frame open")
  `FDD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && !skid_valid_r), "output buffer not cleared by reset")

endmodule

FILE: dv/frame_deframer_dd_77_top_test.sv
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Drives reply-frame bytes through the checker under random valid/stall gaps
// and compares every result beat against an in-bench frame predictor. Covers
// clean frames, every rejection status, aborts, restarts, index wrap on long
// frames and several register settings, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_deframer_dd_77_top_test;
  import fdd77_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
    logic             abrt;
  } rx_beat_t;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_SUM_HI,
    FRAME_BAD_SUM_LO,
    FRAME_BAD_END,
    FRAME_BAD_END_SUM
  } frame_fault_t;

  typedef enum int {CUT_NONE, CUT_ABORT, CUT_DROP, CUT_PAUSE} cut_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   in_rx_byte = '0;
  logic               in_frame_start = 1'b0;
  logic               in_abort = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ByteW-1:0]   out_echo_byte;
  logic [IdxW-1:0]    out_byte_index;
  logic               out_last;
  logic [2:0]         out_status;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_wdata = '0;

  frame_deframer_dd_77_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .in_abort       (in_abort),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_echo_byte  (out_echo_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  rx_beat_t rx_beats_q[$];
  result_t  expected_q[$];

  int idle_pct = 14;
  int stim_count = 0;
  int beats_taken = 0;
  int results_checked = 0;
  int fail_count = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int status_hits[6];

  // Register copies
  logic [ByteW-1:0] end_marker = END_BYTE_RST;
  logic [ByteW-1:0] max_len    = MAX_PAYLOAD_RST;
  logic [ByteW-1:0] cmd_min    = COMMAND_LOW_RST;
  logic [ByteW-1:0] cmd_max    = COMMAND_HIGH_RST;

  // Predicted frame state
  phase_t           frame_phase = PH_IDLE;
  logic [IdxW-1:0]  next_pos = '0;
  logic [ByteW-1:0] len_left = '0;
  logic             len_hi_set = 1'b0;
  logic             cmd_in_range = 1'b0;
  logic [SumW-1:0]  sum_acc = '0;
  logic [ByteW-1:0] sum_hi_rx = '0;

  // Advances the frame state by one accepted byte; returns 1 when a result beat follows.
  function automatic bit predict_beat(input logic [ByteW-1:0] b, input logic start,
                                      input logic abrt, output result_t r);
    logic [IdxW-1:0] idx;
    logic [SumW-1:0] want_sum;
    r = '0;
    if (abrt) begin
      if (frame_phase == PH_IDLE && !start) return 1'b0;
      r.byte_index = (frame_phase != PH_IDLE) ? next_pos : '0;
      r.last = 1'b1;
      r.status = ST_ABORTED;
      frame_phase = PH_IDLE;
      return 1'b1;
    end
    if (start) begin
      cmd_in_range = (b >= cmd_min) && (b <= cmd_max);
      sum_acc = '0;
      len_hi_set = 1'b0;
      len_left = '0;
      frame_phase = PH_HEAD;
      next_pos = 6'd1;
      r.echo_byte = b;
      return 1'b1;
    end
    if (frame_phase == PH_IDLE) return 1'b0;

    idx = next_pos;
    next_pos = next_pos + 6'd1;
    r.echo_byte = b;
    r.byte_index = idx;
    case (frame_phase)
      PH_HEAD: begin
        sum_acc = sum_acc + 16'(b);
        if (idx == 6'd1) begin
          len_hi_set = (b != 8'd0);
        end else if (!cmd_in_range) begin
          frame_phase = PH_IDLE;
          r.last = 1'b1;
          r.status = ST_BAD_CMD;
        end else if (len_hi_set || b > max_len) begin
          frame_phase = PH_IDLE;
          r.last = 1'b1;
          r.status = ST_TOO_LONG;
        end else begin
          len_left = b;
          frame_phase = (b != 8'd0) ? PH_PAYLOAD : PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        sum_acc = sum_acc + 16'(b);
        len_left = len_left - 8'd1;
        if (len_left == 8'd0) frame_phase = PH_TRAILER;
      end
      default: begin
        // trailer: len_left counts trailer bytes seen, sum_acc turns into a mismatch flag
        if (len_left == 8'd0) begin
          sum_hi_rx = b;
          len_left = 8'd1;
        end else if (len_left == 8'd1) begin
          want_sum = ~sum_acc + 16'd1;
          sum_acc = (sum_hi_rx != want_sum[15:8] || b != want_sum[7:0]) ? 16'd1 : 16'd0;
          len_left = 8'd2;
        end else begin
          frame_phase = PH_IDLE;
          r.last = 1'b1;
          if (b != end_marker) r.status = ST_BAD_END;
          else if (sum_acc != 16'd0) r.status = ST_BAD_SUM;
          else r.status = ST_OK;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : drive_beats
    rx_beat_t nxt;
    result_t  res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
      in_frame_start <= 1'b0;
      in_abort <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        beats_taken++;
        if (predict_beat(in_rx_byte, in_frame_start, in_abort, res)) expected_q.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (rx_beats_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = rx_beats_q.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= nxt.data;
          in_frame_start <= nxt.start;
          in_abort <= nxt.abrt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (out_last && out_status <= ST_ABORTED) status_hits[out_status]++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected beat echo=%h idx=%0d last=%b status=%0d",
                                 out_echo_byte, out_byte_index, out_last, out_status));
        end else begin
          want = expected_q.pop_front();
          if (out_echo_byte !== want.echo_byte || out_byte_index !== want.byte_index ||
              out_last !== want.last || out_status !== want.status)
            note_failure($sformatf({"result %0d: expected echo=%h idx=%0d last=%b status=%0d",
                                    ", got echo=%h idx=%0d last=%b status=%0d"},
                                   results_checked, want.echo_byte, want.byte_index,
                                   want.last, want.status, out_echo_byte, out_byte_index,
                                   out_last, out_status));
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Hang detection: nothing moving on any port for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(input logic [ByteW-1:0] data, input logic start, input logic abrt,
                           input bit counted);
    rx_beat_t t;
    t.data = data;
    t.start = start;
    t.abrt = abrt;
    rx_beats_q.push_back(t);
    if (counted) stim_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_beats_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_END_BYTE:    end_marker = val;
      CFG_MAX_PAYLOAD: max_len = val;
      CFG_COMMAND_LOW: cmd_min = val;
      default:         cmd_max = val;
    endcase
  endtask

  task automatic apply_settings(input logic [ByteW-1:0] end_val, input logic [ByteW-1:0] max_val,
                                input logic [ByteW-1:0] lo_val, input logic [ByteW-1:0] hi_val);
    // a trailing stray byte may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_END_BYTE, end_val);
    write_reg(CFG_MAX_PAYLOAD, max_val);
    write_reg(CFG_COMMAND_LOW, lo_val);
    write_reg(CFG_COMMAND_HIGH, hi_val);
    settings_used++;
  endtask

  // Builds one frame, optionally cut at byte cut_at; a rejected header stops after the low length byte.
  // fill < 0 gives random payload bytes.
  task automatic queue_frame(input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] len_hi,
                             input logic [ByteW-1:0] len_lo, input int fill,
                             input frame_fault_t fault, input cut_t cut_kind, input int cut_at);
    logic [ByteW-1:0] bytes[$];
    logic [SumW-1:0]  sum;
    logic [ByteW-1:0] p;
    logic [ByteW-1:0] tail;
    int               i;
    bytes.push_back(cmd);
    bytes.push_back(len_hi);
    bytes.push_back(len_lo);
    if (cmd >= cmd_min && cmd <= cmd_max && len_hi == 8'd0 && len_lo <= max_len) begin
      sum = 16'(len_hi) + 16'(len_lo);
      for (i = 0; i < int'(len_lo); i++) begin
        p = (fill < 0) ? 8'($urandom) : 8'(fill);
        bytes.push_back(p);
        sum = sum + 16'(p);
      end
      sum = ~sum + 16'd1;
      if (fault == FRAME_BAD_SUM_HI) sum[15:8] ^= 8'($urandom_range(1, 255));
      if (fault == FRAME_BAD_SUM_LO || fault == FRAME_BAD_END_SUM)
        sum[7:0] ^= 8'($urandom_range(1, 255));
      tail = end_marker;
      if (fault == FRAME_BAD_END || fault == FRAME_BAD_END_SUM)
        tail ^= 8'($urandom_range(1, 255));
      bytes.push_back(sum[15:8]);
      bytes.push_back(sum[7:0]);
      bytes.push_back(tail);
    end
    for (i = 0; i < bytes.size(); i++) begin
      if (i == cut_at && cut_kind == CUT_ABORT) begin
        push_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
        return;
      end
      if (i == cut_at && cut_kind == CUT_DROP) return;
      if (i == cut_at && cut_kind == CUT_PAUSE) wait_drained();
      push_beat(bytes[i], (i == 0), 1'b0, 1'b1);
    end
  endtask

  task automatic queue_random_frame();
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] len_hi;
    logic [ByteW-1:0] len_lo;
    int               pick;
    int               cap;
    frame_fault_t     fault;
    cut_t             cut_kind;
    if ($urandom_range(0, 99) < 85) cmd = 8'($urandom_range(cmd_min, cmd_max));
    else cmd = 8'($urandom);
    len_hi = 8'd0;
    cap = ($urandom_range(0, 4) == 0) ? 70 : 12;
    if (cap > int'(max_len)) cap = int'(max_len);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      if (max_len == 8'hFF || $urandom_range(0, 1) == 0) begin
        len_hi = 8'($urandom_range(1, 255));
        len_lo = 8'($urandom);
      end else begin
        len_lo = 8'($urandom_range(int'(max_len) + 1, 255));
      end
    end else if (pick < 14) begin
      len_lo = max_len;
    end else begin
      len_lo = 8'($urandom_range(0, cap));
    end

    pick = $urandom_range(0, 99);
    if (pick < 70) fault = FRAME_CLEAN;
    else if (pick < 78) fault = FRAME_BAD_SUM_HI;
    else if (pick < 86) fault = FRAME_BAD_SUM_LO;
    else if (pick < 93) fault = FRAME_BAD_END;
    else fault = FRAME_BAD_END_SUM;

    pick = $urandom_range(0, 99);
    if (pick < 5) cut_kind = CUT_ABORT;
    else if (pick < 10) cut_kind = CUT_DROP;
    else if (pick < 11) cut_kind = CUT_PAUSE;
    else cut_kind = CUT_NONE;

    queue_frame(cmd, len_hi, len_lo, -1, fault, cut_kind,
                $urandom_range(1, int'(len_lo) + 5));
  endtask

  // Line noise: stray bytes, occasional aborts, never a frame start
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) push_beat(8'($urandom), 1'b0, ($urandom_range(0, 9) == 0), 1'b0);
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = stim_count + n_items;
    while (stim_count < stop_at) begin
      if ($urandom_range(0, 99) < 8) queue_noise();
      else queue_random_frame();
    end
  endtask

  initial begin : run_test
    logic [ByteW-1:0] lo;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: end 0x77, payload up to 52, commands 3..5
    push_beat(8'hAA, 1'b0, 1'b0, 1'b1);  // stray byte while idle
    push_beat(8'h5C, 1'b0, 1'b1, 1'b1);  // abort while idle
    // zero length, sender holds mid-frame until all results are back
    queue_frame(8'h03, 8'h00, 8'h00, -1, FRAME_CLEAN, CUT_PAUSE, 3);
    // bad command wins over a nonzero high length byte
    queue_frame(8'h02, 8'h01, 8'h00, -1, FRAME_CLEAN, CUT_NONE, 0);
    queue_frame(8'h05, 8'h00, 8'd53, -1, FRAME_CLEAN, CUT_NONE, 0);
    push_beat(8'hFF, 1'b1, 1'b1, 1'b1);  // abort together with frame start
    push_beat(8'h04, 1'b1, 1'b0, 1'b1);  // dropped by the restart below
    queue_frame(8'h03, 8'h00, 8'd52, -1, FRAME_CLEAN, CUT_ABORT, 2);
    queue_frame(8'h04, 8'h00, 8'h01, 8'hFF, FRAME_BAD_SUM_HI, CUT_NONE, 0);
    // bad end wins over a bad checksum
    queue_frame(8'h05, 8'h00, 8'h00, -1, FRAME_BAD_END_SUM, CUT_NONE, 0);
    wait_drained();

    apply_settings(8'h00, 8'h00, 8'h00, 8'h00);
    run_random(250);
    wait_drained();

    apply_settings(8'hFF, 8'hFF, 8'h00, 8'hFF);
    queue_frame(8'h80, 8'h00, 8'd200, -1, FRAME_CLEAN, CUT_NONE, 0);  // index wraps
    run_random(500);
    wait_drained();

    lo = 8'($urandom);
    apply_settings(8'($urandom), 8'($urandom_range(1, 40)), lo,
                   8'($urandom_range(int'(lo), 255)));
    run_random(450);
    wait_drained();

    idle_pct = 0;
    apply_settings(END_BYTE_RST, MAX_PAYLOAD_RST, COMMAND_LOW_RST, COMMAND_HIGH_RST);
    run_random(450);
    wait_drained();

    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      note_failure($sformatf("%0d expected result beats never arrived", expected_q.size()));

    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             beats_taken, results_checked, settings_used + 1);
    $display({"Frame endings: %0d ok, %0d bad command, %0d too long, %0d bad end,",
              " %0d bad sum, %0d aborted"},
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
